// ----- rtl/nmea_rmc_pkg.sv -----
// Shared types, constants and helper functions for the RMC sentence extractor.
package nmea_rmc_pkg;

   // Sentence geometry
   localparam int HDR_LEN              = 6;
   localparam int MAX_SENTENCE_DEFAULT = 128;
   localparam int POS_W                = 7;
   localparam int BYTE_W               = 8;
   localparam int HDR_IDX_W            = 3;

   // Characters of interest
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;

   localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);
   localparam logic [4:0]           HEX_NONE     = 5'd16;

   // One result descriptor handed from the parser to the output stage
   typedef struct packed {
      logic             hdr;    // start of the six-byte header burst
      logic             gn;     // header talker is GN rather than GP
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
      logic             abort;
   } res_type;

   // Hex digit value, HEX_NONE when not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c >= CH_0 && c <= CH_9) begin
         v = {1'b0, 4'(c - CH_0)};
      end else if (c >= CH_UA && c <= CH_UF) begin
         v = {1'b0, 4'(c - CH_UA + 8'd10)};
      end else if (c >= CH_LA && c <= CH_LF) begin
         v = {1'b0, 4'(c - CH_LA + 8'd10)};
      end
      return v;
   endfunction

   // Header character at a given burst index
   function automatic logic [7:0] hdr_char(input logic [HDR_IDX_W-1:0] idx, input logic gn);
      logic [7:0] c;
      case (idx)
         3'd0:    c = CH_DOLLAR;
         3'd1:    c = CH_G;
         3'd2:    c = gn ? CH_N : CH_P;
         3'd3:    c = CH_R;
         3'd4:    c = CH_M;
         3'd5:    c = CH_C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // XOR of header bytes after the dollar sign
   function automatic logic [7:0] hdr_xor(input logic gn);
      return CH_G ^ (gn ? CH_N : CH_P) ^ CH_R ^ CH_M ^ CH_C;
   endfunction

endpackage

// ----- rtl/nmea_rmc_sentence_extractor_core.sv -----
// Top level of the RMC sentence extractor: input register, parser and result stage.
//
// Usage: serial characters enter on the req_ channel, one item per byte.
// While no sentence is open the block hunts for "$GPRMC" or "$GNRMC"; on a
// hit it delivers the six header bytes at positions 0 to 5 on the rsp_
// channel, then every later byte with its position. The item that carries
// a matching "*hh" checksum digit has rsp_last set and the parser clears.
// A sentence that reaches MAX_SENTENCE bytes yields one item with rsp_abort
// set (byte and position zero) and the parser clears.
// An accepted item passes the input register and then the result register
// before it can be taken from rsp_. Throughput: one item per cycle while
// rsp_stall is low and no header burst runs; a header hit puts six result
// items out in turn from the single result register while req_stall holds.
// Reset: synchronous, clears the parser and drops both pipeline registers.
// When rsp_stall is high the result is held; the input register then fills
// and req_stall rises until the result stage frees.
module nmea_rmc_sentence_extractor_core #(
   parameter int MAX_SENTENCE = nmea_rmc_pkg::MAX_SENTENCE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [6:0] rsp_position,
   output logic       rsp_last,
   output logic       rsp_abort
);
   import nmea_rmc_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       consume;
   logic       out_free;
   logic       res_vld;
   res_type    res;

   // Input register
   assign consume   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !consume;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
      end else if (consume) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Parser
   nmea_rmc_parse #(
      .MAX_SENTENCE (MAX_SENTENCE)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .consume (consume),
      .in_byte (in_byte_ff),
      .res_vld (res_vld),
      .res     (res)
   );

   // Result stage
   nmea_rmc_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (consume),
      .res_vld      (res_vld),
      .res          (res),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .rsp_abort    (rsp_abort)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("stall raised with empty input register");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !consume) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("unconsumed item lost");

   a_free_moves: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && in_vld_ff) |-> consume)
      else $error("input held while result stage empty");

endmodule

// ----- rtl/nmea_rmc_parse.sv -----
// Parser state: header hunting window, running XOR, checksum check and fill count.
module nmea_rmc_parse #(
   parameter int MAX_SENTENCE = nmea_rmc_pkg::MAX_SENTENCE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  consume,
   input  logic [7:0]            in_byte,
   output logic                  res_vld,
   output nmea_rmc_pkg::res_type res
);
   import nmea_rmc_pkg::*;

   localparam int FILL_W = $clog2(MAX_SENTENCE + 1);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        xor_ff, xor_in;
   logic [7:0]        prev1_ff, prev1_in;   // previous byte
   logic [7:0]        prev2_ff, prev2_in;   // byte before that
   logic [7:0]        win_ff [HDR_LEN];
   logic [7:0]        win_in [HDR_LEN];

   logic              hdr_ok;
   logic              gn;
   logic [4:0]        hi_val;
   logic [4:0]        lo_val;
   logic              sum_ok;

   // Header compare on the window as it will stand after this byte
   always_comb begin
      for (int i = 0; i < HDR_LEN - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[HDR_LEN-1] = in_byte;
      gn     = (win_in[2] == CH_N);
      hdr_ok = (win_in[0] == CH_DOLLAR) && (win_in[1] == CH_G) &&
               ((win_in[2] == CH_P) || (win_in[2] == CH_N)) &&
               (win_in[3] == CH_R) && (win_in[4] == CH_M) && (win_in[5] == CH_C);
   end

   // Checksum check: '*' two back, two hex digits equal to XOR before the '*'
   always_comb begin
      hi_val = hex_value(prev1_ff);
      lo_val = hex_value(in_byte);
      sum_ok = (prev2_ff == CH_STAR) && !hi_val[4] && !lo_val[4] &&
               ((xor_ff ^ prev1_ff ^ prev2_ff) == {hi_val[3:0], lo_val[3:0]});
   end

   // Next state and result descriptor
   always_comb begin
      fill_in   = fill_ff;
      xor_in    = xor_ff;
      prev1_in  = prev1_ff;
      prev2_in  = prev2_ff;
      res_vld   = 1'b0;
      res.hdr   = 1'b0;
      res.gn    = gn;
      res.data  = in_byte;
      res.pos   = POS_W'(fill_ff);
      res.last  = 1'b0;
      res.abort = 1'b0;
      if (fill_ff < FILL_W'(HDR_LEN)) begin
         // hunting for the header
         fill_in = fill_ff + 1'b1;
         if (fill_ff == FILL_W'(HDR_LEN - 1)) begin
            if (hdr_ok) begin
               fill_in  = FILL_W'(HDR_LEN);
               xor_in   = hdr_xor(gn);
               prev1_in = CH_C;
               prev2_in = CH_M;
               res_vld  = 1'b1;
               res.hdr  = 1'b1;
               res.data = CH_DOLLAR;
               res.pos  = '0;
            end else begin
               fill_in = FILL_W'(HDR_LEN - 1);
            end
         end
      end else if (fill_ff >= FILL_W'(MAX_SENTENCE)) begin
         // overflow: discard the sentence
         res_vld   = 1'b1;
         res.data  = '0;
         res.pos   = '0;
         res.abort = 1'b1;
         fill_in   = '0;
         xor_in    = '0;
         prev1_in  = '0;
         prev2_in  = '0;
      end else begin
         res_vld  = 1'b1;
         res.last = sum_ok;
         if (sum_ok) begin
            fill_in  = '0;
            xor_in   = '0;
            prev1_in = '0;
            prev2_in = '0;
         end else begin
            fill_in  = fill_ff + 1'b1;
            xor_in   = xor_ff ^ in_byte;
            prev1_in = in_byte;
            prev2_in = prev1_ff;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         xor_ff   <= '0;
         prev1_ff <= '0;
         prev2_ff <= '0;
      end else if (consume) begin
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
      end
   end

   // Sliding window, only moves while hunting
   always_ff @(posedge clock) begin
      if (consume && (fill_ff < FILL_W'(HDR_LEN))) begin
         win_ff <= win_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_SENTENCE))
      else $error("fill count beyond sentence limit");

   a_hdr_pos0: assert property (@(posedge clock) disable iff (reset)
      (res_vld && res.hdr) |-> (fill_ff == FILL_W'(HDR_LEN - 1)))
      else $error("header burst outside hunting");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (consume && res_vld && (res.last || res.abort)) |=> (fill_ff == '0))
      else $error("parser not cleared after sentence end");

endmodule

// ----- rtl/nmea_rmc_out.sv -----
// Result register with header burst sequencing.
module nmea_rmc_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  res_vld,
   input  nmea_rmc_pkg::res_type res,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic [6:0]            rsp_position,
   output logic                  rsp_last,
   output logic                  rsp_abort
);
   import nmea_rmc_pkg::*;

   logic                 vld_ff, vld_in;
   logic                 hdr_ff, hdr_in;
   logic                 gn_ff, gn_in;
   logic [HDR_IDX_W-1:0] cnt_ff, cnt_in;
   logic [7:0]           data_ff, data_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 last_ff, last_in;
   logic                 abort_ff, abort_in;
   logic                 fire;
   logic                 final_beat;

   assign fire       = vld_ff && !rsp_stall;
   assign final_beat = !hdr_ff || (cnt_ff == HDR_LAST_IDX);
   assign out_free   = !vld_ff || (fire && final_beat);

   // Next value: load a new descriptor, step through the header burst, or drop valid after the final beat
   always_comb begin
      vld_in   = vld_ff;
      hdr_in   = hdr_ff;
      gn_in    = gn_ff;
      cnt_in   = cnt_ff;
      data_in  = data_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      abort_in = abort_ff;
      if (load) begin
         vld_in   = res_vld;
         hdr_in   = res.hdr;
         gn_in    = res.gn;
         cnt_in   = '0;
         data_in  = res.data;
         pos_in   = res.pos;
         last_in  = res.last;
         abort_in = res.abort;
      end else if (fire) begin
         if (final_beat) begin
            vld_in = 1'b0;
         end else begin
            cnt_in  = cnt_ff + 1'b1;
            data_in = hdr_char(cnt_ff + 1'b1, gn_ff);
            pos_in  = POS_W'(cnt_ff + 1'b1);
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         hdr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         hdr_ff <= hdr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      gn_ff    <= gn_in;
      data_ff  <= data_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
      abort_ff <= abort_in;
   end

   assign rsp_valid    = vld_ff;
   assign rsp_out_byte = data_ff;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;
   assign rsp_abort    = abort_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (cnt_ff <= HDR_LAST_IDX))
      else $error("header burst index out of range");

   a_last_abort: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> !(last_ff && abort_ff))
      else $error("last and abort together");

   a_burst_step: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && hdr_ff && !rsp_stall && !final_beat) |=> (vld_ff && (pos_ff == $past(pos_ff) + 1'b1)))
      else $error("header burst did not advance");

endmodule
